/* src/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is switched off while reset is applied.
`define PFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define PFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

/* src/pfa_pkg.sv */
// Types and constants of the partition allocator.
// No dependencies.
package pfa_pkg;
  localparam int ADDR_BITS = 16;
  localparam int ID_BITS = 16;
  localparam int DEF_MAX_PARTS = 64;
  localparam logic [15:0] TOTAL_RESET = 16'd10240;
  localparam logic [15:0] MIN_SPLIT_RESET = 16'd12;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_NEXT = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_BADID = 2'd2,
    STAT_RSVD = 2'd3
  } status_e;

  typedef enum logic {
    CFG_TOTAL = 1'b0,
    CFG_MIN_SPLIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_SCAN, ST_DECIDE, ST_MOD, ST_DEL, ST_DONE
  } state_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic [ID_BITS-1:0] ident;
    logic busy;
  } entry_t;

  typedef struct packed {
    logic shift;
    entry_t tail;
    logic load;
    entry_t load_ent;
  } ring_ctrl_t;

  typedef struct packed {
    status_e status;
    logic [15:0] result_id;
    logic [15:0] result_start;
    logic [6:0] free_parts;
    logic [6:0] busy_parts;
  } result_t;
endpackage

/* src/pfa_if.sv */
// Handshake channels for requests and results.
// Depends on pfa_pkg.
interface pfa_req_if import pfa_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [15:0] req_size;
  logic [15:0] part_id;
  modport source (output valid, mode, req_size, part_id, input ready);
  modport sink (input valid, mode, req_size, part_id, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [15:0] result_id;
  logic [15:0] result_start;
  logic [6:0] free_parts;
  logic [6:0] busy_parts;
  modport source (output valid, status, result_id, result_start, free_parts, busy_parts,
                  input ready);
  modport sink (input valid, status, result_id, result_start, free_parts, busy_parts,
                output ready);
endinterface

/* src/partition_first_next_fit_allocator_core.sv */
// Top level of the first fit and next fit partition allocator.
// Depends on pfa_pkg, pfa_if, pfa_cell, pfa_ctrl and assert_macros.svh.
//
// The partition table lives in a ring of MAX_PARTS cells that rotates one
// place a cycle, while a request is scanned or rewritten, past a sequencer
// reading the head cell. One request takes one rotation to scan the table,
// one to rewrite it and one more for each partition beyond the first that a
// release merge removes. After acceptance the sequencer scans the table,
// decides in ST_DECIDE, rewrites the table and then loads the result
// register; when nothing fits, the id is unknown or the mode is unused there
// is no rewrite. One request is in work at a time; a result word may wait
// at the output while the next request is accepted, and a finished request
// stalls until the word before it has been taken. After reset the table is
// loaded in ST_INIT before the first request is taken, and a write of the
// total size takes the place of a request.
`include "assert_macros.svh"
module partition_first_next_fit_allocator_core import pfa_pkg::*; #(
  parameter int MAX_PARTS = DEF_MAX_PARTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  pfa_req_if.sink     req_i,
  pfa_rsp_if.source   rsp_o
);
  entry_t     ent [MAX_PARTS];
  ring_ctrl_t ring;
  result_t    res;

  pfa_ctrl #(.MAX_PARTS(MAX_PARTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .mode_i      (req_i.mode),
    .req_size_i  (req_i.req_size),
    .part_id_i   (req_i.part_id),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (res),
    .head_i      (ent[0]),
    .next_i      (ent[1]),
    .ring_o      (ring)
  );

  for (genvar k = 0; k < MAX_PARTS; k++) begin : g_cell
    pfa_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (ring.shift),
      .nb_i       ((k == MAX_PARTS - 1) ? ring.tail : ent[(k + 1) % MAX_PARTS]),
      .load_i     ((k == 0) ? ring.load : 1'b0),
      .load_ent_i (ring.load_ent),
      .ent_o      (ent[k])
    );
  end

  assign rsp_o.status       = res.status;
  assign rsp_o.result_id    = res.result_id;
  assign rsp_o.result_start = res.result_start;
  assign rsp_o.free_parts   = res.free_parts;
  assign rsp_o.busy_parts   = res.busy_parts;

  `PFA_ASSERT(a_load_excl, !(ring.load && ring.shift), "ring load during rotation")
  `PFA_ASSERT(a_shift_busy, ring.shift |-> !req_i.ready, "request taken while table moves")
  `PFA_ASSERT(a_one_item, (req_i.valid && req_i.ready && !cfg_we_i) |=> !req_i.ready,
              "second request taken while one is in work")
endmodule

/* src/pfa_cell.sv */
// One table cell of the rotating partition ring.
// Depends on pfa_pkg.
module pfa_cell import pfa_pkg::*; (
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t nb_i,
  input  logic   load_i,
  input  entry_t load_ent_i,
  output entry_t ent_o
);
  entry_t ent_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= load_ent_i;
    end else if (shift_i) begin
      ent_q <= nb_i;
    end
  end

  assign ent_o = ent_q;
endmodule

/* src/pfa_ctrl.sv */
// Sequencer that scans and rewrites the partition ring.
// Depends on pfa_pkg; drives the cells through a ring_ctrl_t.
module pfa_ctrl import pfa_pkg::*; #(
  parameter int MAX_PARTS = DEF_MAX_PARTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] req_size_i,
  input  logic [15:0] part_id_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output result_t     rsp_o,
  input  entry_t      head_i,
  input  entry_t      next_i,
  output ring_ctrl_t  ring_o
);
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam int PW = $clog2(MAX_PARTS);

  state_e state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [CW-1:0] count_q, count_d, busy_q, busy_d, rover_q, rover_d, first_q, first_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [ID_BITS-1:0] idc_q, idc_d;
  logic [15:0] total_q, total_d, minsp_q, minsp_d, req_q, req_d, pid_q, pid_d;
  mode_e mode_q, mode_d;
  logic hf_q, hf_d, lf_q, lf_d;
  logic [PW-1:0] hi_idx_q, hi_idx_d, lo_idx_q, lo_idx_d, tgt_q, tgt_d;
  entry_t hi_ent_q, hi_ent_d, lo_ent_q, lo_ent_d, new_q, new_d, hold_q, hold_d;
  logic split_q, split_d;
  logic run_act_q, run_act_d, rf_q, rf_d, after_q, after_d;
  logic [PW-1:0] run_lo_q, run_lo_d, lo_q, lo_d, hi_q, hi_d;
  logic [ADDR_BITS-1:0] run_start_q, run_start_d, run_sum_q, run_sum_d;
  logic [ADDR_BITS-1:0] lo_start_q, lo_start_d, sum_q, sum_d;
  result_t res_q, res_d, out_q, out_d;
  logic out_v_q, out_v_d;

  logic [CW-1:0] p_ext, i1, lo1, hi1, dcnt;
  logic vld, fit, have, splt;
  logic [PW-1:0] ci;
  entry_t ce;
  logic [ADDR_BITS-1:0] rest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      pos_q <= '0;
      count_q <= CW'(1);
      busy_q <= '0;
      rover_q <= '0;
      rem_q <= '0;
      idc_q <= '0;
      total_q <= TOTAL_RESET;
      minsp_q <= MIN_SPLIT_RESET;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      count_q <= count_d;
      busy_q <= busy_d;
      rover_q <= rover_d;
      rem_q <= rem_d;
      idc_q <= idc_d;
      total_q <= total_d;
      minsp_q <= minsp_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    req_q <= req_d;
    pid_q <= pid_d;
    mode_q <= mode_d;
    hf_q <= hf_d;
    lf_q <= lf_d;
    hi_idx_q <= hi_idx_d;
    lo_idx_q <= lo_idx_d;
    tgt_q <= tgt_d;
    hi_ent_q <= hi_ent_d;
    lo_ent_q <= lo_ent_d;
    new_q <= new_d;
    hold_q <= hold_d;
    split_q <= split_d;
    run_act_q <= run_act_d;
    rf_q <= rf_d;
    after_q <= after_d;
    run_lo_q <= run_lo_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    run_start_q <= run_start_d;
    run_sum_q <= run_sum_d;
    lo_start_q <= lo_start_d;
    sum_q <= sum_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    count_d = count_q;
    busy_d = busy_q;
    rover_d = rover_q;
    rem_d = rem_q;
    idc_d = idc_q;
    total_d = total_q;
    minsp_d = minsp_q;
    first_d = first_q;
    req_d = req_q;
    pid_d = pid_q;
    mode_d = mode_q;
    hf_d = hf_q;
    lf_d = lf_q;
    hi_idx_d = hi_idx_q;
    lo_idx_d = lo_idx_q;
    tgt_d = tgt_q;
    hi_ent_d = hi_ent_q;
    lo_ent_d = lo_ent_q;
    new_d = new_q;
    hold_d = hold_q;
    split_d = split_q;
    run_act_d = run_act_q;
    rf_d = rf_q;
    after_d = after_q;
    run_lo_d = run_lo_q;
    lo_d = lo_q;
    hi_d = hi_q;
    run_start_d = run_start_q;
    run_sum_d = run_sum_q;
    lo_start_d = lo_start_q;
    sum_d = sum_q;
    res_d = res_q;
    out_d = out_q;
    out_v_d = out_v_q;
    req_ready_o = 1'b0;
    ring_o.shift = 1'b0;
    ring_o.tail = head_i;
    ring_o.load = 1'b0;
    ring_o.load_ent = '{start: '0, size: total_q, ident: '0, busy: 1'b0};

    p_ext = CW'(pos_q);
    vld = p_ext < count_q;
    fit = vld && (req_q != '0) && !head_i.busy && (head_i.size >= req_q);
    have = hf_q || lf_q;
    ci = hf_q ? hi_idx_q : lo_idx_q;
    ce = hf_q ? hi_ent_q : lo_ent_q;
    rest = ce.size - req_q;
    splt = (rest > minsp_q) && (count_q < CW'(MAX_PARTS));
    i1 = CW'(ci) + CW'(1);
    lo1 = CW'(lo_q) + CW'(1);
    hi1 = CW'(hi_q) + CW'(1);
    dcnt = CW'(hi_q - lo_q);

    if (out_v_q && rsp_ready_i) begin
      out_v_d = 1'b0;
    end
    if (cfg_we_i && (cfg_idx_i == CFG_MIN_SPLIT)) begin
      minsp_d = cfg_data_i;
    end

    unique case (state_q)
      ST_INIT: begin
        ring_o.load = 1'b1;
        if (cfg_we_i && (cfg_idx_i == CFG_TOTAL)) begin
          total_d = cfg_data_i;
          ring_o.load_ent.size = cfg_data_i;
        end
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (cfg_we_i && (cfg_idx_i == CFG_TOTAL)) begin
          req_ready_o = 1'b0;
          total_d = cfg_data_i;
          ring_o.load = 1'b1;
          ring_o.load_ent.size = cfg_data_i;
          count_d = CW'(1);
          busy_d = '0;
          rover_d = '0;
        end else if (req_valid_i) begin
          mode_d = mode_e'(mode_i);
          req_d = req_size_i;
          pid_d = part_id_i;
          first_d = ((mode_e'(mode_i) == MODE_NEXT) && (rover_q < count_q)) ? rover_q : '0;
          hf_d = 1'b0;
          lf_d = 1'b0;
          run_act_d = 1'b0;
          rf_d = 1'b0;
          after_d = 1'b0;
          pos_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ring_o.shift = 1'b1;
        if (mode_q == MODE_FIRST || mode_q == MODE_NEXT) begin
          if (fit && (p_ext >= first_q) && !hf_q) begin
            hf_d = 1'b1;
            hi_idx_d = pos_q;
            hi_ent_d = head_i;
          end
          if (fit && (p_ext < first_q) && !lf_q) begin
            lf_d = 1'b1;
            lo_idx_d = pos_q;
            lo_ent_d = head_i;
          end
        end else if (mode_q == MODE_RELEASE) begin
          if (vld && !rf_q) begin
            if (!head_i.busy) begin
              if (run_act_q) begin
                run_sum_d = run_sum_q + head_i.size;
              end else begin
                run_act_d = 1'b1;
                run_lo_d = pos_q;
                run_start_d = head_i.start;
                run_sum_d = head_i.size;
              end
            end else if (head_i.ident == pid_q) begin
              rf_d = 1'b1;
              after_d = 1'b1;
              lo_d = run_act_q ? run_lo_q : pos_q;
              lo_start_d = run_act_q ? run_start_q : head_i.start;
              sum_d = (run_act_q ? run_sum_q : '0) + head_i.size;
              hi_d = pos_q;
            end else begin
              run_act_d = 1'b0;
            end
          end else if (vld && after_q && !head_i.busy) begin
            sum_d = sum_q + head_i.size;
            hi_d = pos_q;
          end else begin
            after_d = 1'b0;
          end
        end
        pos_d = pos_q + PW'(1);
        if (pos_q == PW'(MAX_PARTS - 1)) begin
          pos_d = '0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_d = '{status: STAT_OK, result_id: '0, result_start: '0,
                  free_parts: '0, busy_parts: '0};
        split_d = 1'b0;
        rem_d = '0;
        state_d = ST_DONE;
        if (mode_q == MODE_FIRST || mode_q == MODE_NEXT) begin
          if (have) begin
            split_d = splt;
            tgt_d = ci;
            new_d = '{start: ce.start, size: splt ? req_q : ce.size,
                      ident: ce.ident, busy: 1'b1};
            hold_d = '{start: ce.start + req_q, size: rest, ident: idc_q + ID_BITS'(1),
                       busy: 1'b0};
            if (splt) begin
              idc_d = idc_q + ID_BITS'(1);
              count_d = count_q + CW'(1);
              if (rover_q > i1) rover_d = rover_q + CW'(1);
            end
            busy_d = busy_q + CW'(1);
            if (mode_q == MODE_NEXT) rover_d = i1;
            res_d.result_id = ce.ident;
            res_d.result_start = ce.start;
            state_d = ST_MOD;
          end else begin
            res_d.status = STAT_NOFIT;
            if (mode_q == MODE_NEXT) rover_d = '0;
          end
        end else if (mode_q == MODE_RELEASE) begin
          if (rf_q) begin
            tgt_d = lo_q;
            new_d = '{start: lo_start_q, size: sum_q, ident: idc_q + ID_BITS'(1),
                      busy: 1'b0};
            idc_d = idc_q + ID_BITS'(1);
            count_d = count_q - dcnt;
            busy_d = busy_q - CW'(1);
            rem_d = dcnt;
            if ((rover_q >= lo1) && (rover_q <= hi1)) begin
              rover_d = lo1;
            end else if (rover_q > hi1) begin
              rover_d = rover_q - dcnt;
            end
            res_d.result_id = idc_q + ID_BITS'(1);
            res_d.result_start = lo_start_q;
            state_d = ST_MOD;
          end else begin
            res_d.status = STAT_BADID;
          end
        end
        res_d.free_parts = 7'(count_d - busy_d);
        res_d.busy_parts = 7'(busy_d);
      end
      ST_MOD: begin
        ring_o.shift = 1'b1;
        if (pos_q == tgt_q) begin
          ring_o.tail = new_q;
        end else if (pos_q > tgt_q) begin
          if (split_q) begin
            ring_o.tail = hold_q;
            hold_d = head_i;
          end else if (rem_q != '0) begin
            ring_o.tail = next_i;
          end
        end
        pos_d = pos_q + PW'(1);
        if (pos_q == PW'(MAX_PARTS - 1)) begin
          pos_d = '0;
          rem_d = (rem_q != '0) ? rem_q - CW'(1) : rem_q;
          state_d = ((rem_q != '0) && (rem_q != CW'(1))) ? ST_DEL : ST_DONE;
        end
      end
      ST_DEL: begin
        ring_o.shift = 1'b1;
        if (pos_q > tgt_q) ring_o.tail = next_i;
        pos_d = pos_q + PW'(1);
        if (pos_q == PW'(MAX_PARTS - 1)) begin
          pos_d = '0;
          rem_d = rem_q - CW'(1);
          state_d = (rem_q == CW'(1)) ? ST_DONE : ST_DEL;
        end
      end
      ST_DONE: begin
        if (!out_v_q || rsp_ready_i) begin
          out_v_d = 1'b1;
          out_d = res_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_valid_o = out_v_q;
  assign rsp_o = out_q;
endmodule

/* sim/tb_partition_first_next_fit_allocator_core.sv */
// Testbench for the first fit and next fit partition allocator core.
// Drives requests and register writes, predicts every result word and checks it.
// Depends on pfa_pkg, pfa_if and the allocator RTL.
module tb_partition_first_next_fit_allocator_core;
  import pfa_pkg::*;

  localparam int NPARTS = DEF_MAX_PARTS;
  localparam int STALL_LIMIT = 40000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  pfa_req_if req_if ();
  pfa_rsp_if rsp_if ();

  partition_first_next_fit_allocator_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  // Predicted state of the partition table.
  logic [15:0] part_start [NPARTS];
  logic [15:0] part_size  [NPARTS];
  logic [15:0] part_ident [NPARTS];
  logic        part_busy  [NPARTS];
  int          part_count;
  int          busy_count;
  int          rover;
  logic [15:0] last_id;
  logic [15:0] space_total;
  logic [15:0] split_floor;

  result_t     expected_words[$];
  int          mismatches;
  int          idle_cycles;
  bit          no_gaps;
  int          rsp_stall;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void clear_table();
    part_start[0] = '0;
    part_size[0]  = space_total;
    part_ident[0] = '0;
    part_busy[0]  = 1'b0;
    part_count    = 1;
    busy_count    = 0;
    rover         = 0;
  endfunction

  function automatic logic [15:0] next_ident();
    last_id = last_id + 16'd1;
    return last_id;
  endfunction

  function automatic bit fits_at(int i, logic [15:0] req);
    return req != 0 && !part_busy[i] && part_size[i] >= req;
  endfunction

  function automatic void occupy(int i, logic [15:0] req);
    logic [15:0] rest;
    rest = part_size[i] - req;
    if (rest > split_floor && part_count < NPARTS) begin
      for (int j = part_count; j > i + 1; j--) begin
        part_start[j] = part_start[j-1];
        part_size[j]  = part_size[j-1];
        part_ident[j] = part_ident[j-1];
        part_busy[j]  = part_busy[j-1];
      end
      part_start[i+1] = part_start[i] + req;
      part_size[i+1]  = rest;
      part_ident[i+1] = next_ident();
      part_busy[i+1]  = 1'b0;
      part_count++;
      if (rover > i + 1) rover++;
      part_size[i] = req;
    end
    part_busy[i] = 1'b1;
    busy_count++;
  endfunction

  function automatic result_t allocation_outcome(logic [1:0] mode, logic [15:0] req,
                                                 logic [15:0] pid);
    result_t     r;
    int          i;
    int          lo;
    int          hi;
    int          d;
    bit          found;
    logic [15:0] sum;
    r = '0;
    r.status = STAT_OK;
    found = 1'b0;
    if (mode == MODE_FIRST) begin
      for (i = 0; i < part_count; i++) if (fits_at(i, req)) begin
        found = 1'b1;
        break;
      end
      if (found) begin
        occupy(i, req);
        r.result_id = part_ident[i];
        r.result_start = part_start[i];
      end else begin
        r.status = STAT_NOFIT;
      end
    end else if (mode == MODE_NEXT) begin
      i = (rover >= part_count) ? 0 : rover;
      for (int k = 0; k < part_count; k++) begin
        if (fits_at(i, req)) begin
          found = 1'b1;
          break;
        end
        i++;
        if (i >= part_count) i = 0;
      end
      if (found) begin
        occupy(i, req);
        rover = i + 1;
        r.result_id = part_ident[i];
        r.result_start = part_start[i];
      end else begin
        rover = 0;
        r.status = STAT_NOFIT;
      end
    end else if (mode == MODE_RELEASE) begin
      for (i = 0; i < part_count; i++) if (part_busy[i] && part_ident[i] == pid) begin
        found = 1'b1;
        break;
      end
      if (!found) begin
        r.status = STAT_BADID;
      end else begin
        lo = i;
        hi = i;
        while (lo > 0 && !part_busy[lo-1]) lo--;
        while (hi + 1 < part_count && !part_busy[hi+1]) hi++;
        sum = '0;
        for (int j = lo; j <= hi; j++) sum = sum + part_size[j];
        part_size[lo]  = sum;
        part_ident[lo] = next_ident();
        part_busy[lo]  = 1'b0;
        d = hi - lo;
        for (int j = hi + 1; j < part_count; j++) begin
          part_start[j-d] = part_start[j];
          part_size[j-d]  = part_size[j];
          part_ident[j-d] = part_ident[j];
          part_busy[j-d]  = part_busy[j];
        end
        part_count -= d;
        busy_count--;
        if (rover >= lo + 1 && rover <= hi + 1) rover = lo + 1;
        else if (rover > hi + 1) rover -= d;
        r.result_id = part_ident[lo];
        r.result_start = part_start[lo];
      end
    end
    r.free_parts = 7'(part_count - busy_count);
    r.busy_parts = 7'(busy_count);
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(logic [1:0] mode, logic [15:0] req, logic [15:0] pid);
    result_t want;
    repeat (pick_gap()) @(negedge clk_i);
    req_if.valid    = 1'b1;
    req_if.mode     = mode;
    req_if.req_size = req;
    req_if.part_id  = pid;
    do @(posedge clk_i); while (!req_if.ready);
    want = allocation_outcome(mode, req, pid);
    expected_words = {expected_words, want};
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    wait (expected_words.size() == 0);
    repeat (10) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_TOTAL) begin
      space_total = data;
      clear_table();
    end else begin
      split_floor = data;
    end
  endtask

  function automatic bit pick_busy(output logic [15:0] pid);
    logic [15:0] ids[$];
    for (int i = 0; i < part_count; i++) if (part_busy[i]) ids = {ids, part_ident[i]};
    if (ids.size() == 0) return 1'b0;
    pid = ids[$urandom_range(0, ids.size() - 1)];
    return 1'b1;
  endfunction

  task automatic send_random(int bound);
    int          r;
    logic [15:0] pid;
    logic [15:0] req;
    r = $urandom_range(0, 99);
    req = (bound > 1) ? 16'($urandom_range(1, bound)) : 16'd1;
    if ($urandom_range(0, 19) == 0) req = 16'($urandom_range(0, 65535));
    if (r < 30 && pick_busy(pid)) send_word(MODE_RELEASE, 16'($urandom), pid);
    else if (r < 60) send_word(MODE_FIRST, req, 16'($urandom));
    else if (r < 93) send_word(MODE_NEXT, req, 16'($urandom));
    else if (r < 97) send_word(MODE_RELEASE, 16'($urandom), 16'($urandom));
    else send_word(MODE_NONE, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    logic [15:0] pid;
    send_word(MODE_FIRST, 16'd100, 16'd0);
    send_word(MODE_NEXT, 16'd200, 16'd0);
    send_word(MODE_FIRST, 16'd0, 16'd0);
    send_word(MODE_FIRST, 16'hFFFF, 16'hFFFF);
    send_word(MODE_NEXT, 16'hFFFF, 16'd0);
    send_word(MODE_RELEASE, 16'd1, 16'd2);
    send_word(MODE_RELEASE, 16'd1, 16'hFFFF);
    send_word(MODE_NONE, 16'hFFFF, 16'hFFFF);
    send_word(MODE_FIRST, 16'd50, 16'd0);
    send_word(MODE_NEXT, 16'd60, 16'd0);
    if (pick_busy(pid)) send_word(MODE_RELEASE, 16'd0, pid);
    if (pick_busy(pid)) send_word(MODE_RELEASE, 16'd0, pid);
    send_word(MODE_NEXT, 16'd9000, 16'd0);
    send_word(MODE_NEXT, 16'd5, 16'd0);
  endtask

  task automatic test_full_table();
    write_reg(CFG_MIN_SPLIT, 16'd0);
    write_reg(CFG_TOTAL, 16'hFFFF);
    no_gaps = 1'b1;
    for (int n = 0; n < 66; n++) send_word((n % 2) ? MODE_NEXT : MODE_FIRST, 16'd1, 16'd0);
    no_gaps = 1'b0;
    send_word(MODE_FIRST, 16'd1, 16'd0);
    write_reg(CFG_MIN_SPLIT, 16'hFFFF);
    write_reg(CFG_TOTAL, 16'd1);
    send_word(MODE_FIRST, 16'd1, 16'd0);
    send_word(MODE_NEXT, 16'd1, 16'd0);
    send_word(MODE_RELEASE, 16'd0, last_id);
  endtask

  task automatic test_random();
    logic [15:0] totals[5] = '{16'd10240, 16'hFFFF, 16'd300, 16'd4096, 16'd1};
    logic [15:0] floors[5] = '{16'd12, 16'd0, 16'd3, 16'hFFFF, 16'd100};
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_TOTAL, totals[p]);
      write_reg(CFG_MIN_SPLIT, floors[p]);
      no_gaps = (p == 2);
      for (int n = 0; n < 125; n++) send_random(int'(totals[p]) / 10);
    end
    no_gaps = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rsp_stall > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      rsp_stall <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("partition_first_next_fit_allocator_core: mismatch");
      $finish;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        report("unexpected result_id", rsp_if.result_id, 16'd0);
      end else begin
        want = expected_words.pop_front();
        if (rsp_if.status !== want.status) report("status", 16'(rsp_if.status), 16'(want.status));
        if (rsp_if.result_id !== want.result_id)
          report("result_id", rsp_if.result_id, want.result_id);
        if (rsp_if.result_start !== want.result_start)
          report("result_start", rsp_if.result_start, want.result_start);
        if (rsp_if.free_parts !== want.free_parts)
          report("free_parts", 16'(rsp_if.free_parts), 16'(want.free_parts));
        if (rsp_if.busy_parts !== want.busy_parts)
          report("busy_parts", 16'(rsp_if.busy_parts), 16'(want.busy_parts));
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TOTAL;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_FIRST;
    req_if.req_size = '0;
    req_if.part_id = '0;
    rsp_if.ready = 1'b0;
    rsp_stall = 0;
    mismatches = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    last_id = '0;
    space_total = TOTAL_RESET;
    split_floor = MIN_SPLIT_RESET;
    clear_table();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_full_table();
    test_random();
    wait (expected_words.size() == 0);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) $display("partition_first_next_fit_allocator_core: match");
    else $display("partition_first_next_fit_allocator_core: mismatch");
    $finish;
  end
endmodule
